@@ hdl/lobm_pkg.sv @@
package lobm_pkg;

    // Command codes
    localparam logic [2:0] CMD_BUY    = 3'd0;
    localparam logic [2:0] CMD_SELL   = 3'd1;
    localparam logic [2:0] CMD_MODIFY = 3'd2;
    localparam logic [2:0] CMD_CANCEL = 3'd3;
    localparam logic [2:0] CMD_PRINT  = 3'd4;

    // Order types
    localparam logic [1:0] TYPE_GFD = 2'd0;
    localparam logic [1:0] TYPE_IOC = 2'd1;

    // Book sides, also the top bit of the entry address
    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    // Result kinds
    localparam logic [2:0] KIND_TRADE      = 3'd0;
    localparam logic [2:0] KIND_SELL_ENTRY = 3'd1;
    localparam logic [2:0] KIND_BUY_ENTRY  = 3'd2;
    localparam logic [2:0] KIND_EMPTY      = 3'd3;
    localparam logic [2:0] KIND_FULL       = 3'd4;

    // Results per command are capped
    localparam int MAX_RESULTS = 32;
    localparam int RES_CNT_W   = 6;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] price;
        logic [31:0] qty;
    } entry_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] rid;
        logic [31:0] rprice;
        logic [31:0] iid;
        logic [31:0] iprice;
        logic [31:0] qty;
    } result_t;

    typedef struct packed {
        logic    push;
        logic    last;
        result_t res;
    } out_push_t;

endpackage

@@ hdl/limit_order_book_matcher.sv @@
// Channel  Dir  Group     Contents
// in       in   s_axis_*  tuser: command; tdata: id, type, modify side, price, quantity
// out      out  m_axis_*  tuser: result kind; tdata: resting/incoming id and price, qty
//
// One command at a time; s_axis_tready is high only while idle.
// Each book entry visit is a memory read, then use of the data: a search scans
// the sell and buy books, each fill rescans the opposite book, a removal shifts
// the tail down one entry, and print lists every entry.
// Both books live in one synchronous RAM with one read and one write port.
// Reset clears the counts and control; entry storage is not cleared.
// A stalled output holds the sequencer on the step that produces a result.
module limit_order_book_matcher #(
    parameter int BOOK_DEPTH = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,   // order_id, order_type, modify_side,
                                         // limit_price, order_quantity, zero pad
    input  logic [2:0]   s_axis_tuser,   // command
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [159:0] m_axis_tdata,   // resting_id, resting_price, incoming_id,
                                         // incoming_price, fill_quantity
    output logic [2:0]   m_axis_tuser,   // result_kind
    output logic         m_axis_tlast    // last
);
    import lobm_pkg::*;

    localparam int IW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
    localparam int CW = $clog2(BOOK_DEPTH + 1);
    localparam int AW = IW + 1;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_FIND_RD  = 4'd1;
    localparam logic [3:0] S_FIND_CK  = 4'd2;
    localparam logic [3:0] S_SH_RD    = 4'd3;
    localparam logic [3:0] S_SH_WR    = 4'd4;
    localparam logic [3:0] S_MT_START = 4'd5;
    localparam logic [3:0] S_MT_RD    = 4'd6;
    localparam logic [3:0] S_MT_CK    = 4'd7;
    localparam logic [3:0] S_MT_DEC   = 4'd8;
    localparam logic [3:0] S_REST     = 4'd9;
    localparam logic [3:0] S_PR_RD    = 4'd10;
    localparam logic [3:0] S_PR_EM    = 4'd11;
    localparam logic [3:0] S_DONE     = 4'd12;

    logic [3:0]           state_reg, state_next;
    logic [2:0]           cmd_reg, cmd_next;
    logic [31:0]          id_reg, id_next;
    logic [1:0]           type_reg, type_next;
    logic                 mside_reg, mside_next;
    logic [31:0]          price_reg, price_next;
    logic [31:0]          qty_reg, qty_next;
    logic [CW-1:0]        ptr_reg, ptr_next;
    logic                 side_reg, side_next;
    logic                 eside_reg, eside_next;
    logic                 gfd_reg, gfd_next;
    logic                 rmctx_reg, rmctx_next;
    entry_t               best_reg, best_next;
    logic [IW-1:0]        bidx_reg, bidx_next;
    logic                 pend_v_reg, pend_v_next;
    result_t              pend_reg, pend_next;
    logic [RES_CNT_W-1:0] rcnt_reg, rcnt_next;
    logic [CW-1:0]        scnt_reg, scnt_next;
    logic [CW-1:0]        bcnt_reg, bcnt_next;

    logic          rd_en, wr_en;
    logic [AW-1:0] rd_addr, wr_addr;
    entry_t        rd_data, wr_data;
    out_push_t     push;
    logic          can_push;
    logic          emit_req, emit_go;
    result_t       emit_res;
    logic [CW-1:0] cur_cnt, own_cnt, ptr_inc;
    logic [31:0]   fill;
    logic          better, crosses;

    assign cur_cnt = side_reg ? scnt_reg : bcnt_reg;
    assign own_cnt = eside_reg ? scnt_reg : bcnt_reg;
    assign ptr_inc = ptr_reg + 1'b1;
    assign fill    = (qty_reg < best_reg.qty) ? qty_reg : best_reg.qty;
    assign better  = (eside_reg == SIDE_BUY) ? (rd_data.price < best_reg.price)
                                             : (rd_data.price > best_reg.price);
    assign crosses = (eside_reg == SIDE_BUY) ? (best_reg.price <= price_reg)
                                             : (best_reg.price >= price_reg);

    assign s_axis_tready = (state_reg == S_IDLE);

    // Results past the cap are dropped; otherwise wait until the held one can move
    assign emit_go = emit_req && ((rcnt_reg >= RES_CNT_W'(MAX_RESULTS)) ||
                                  !pend_v_reg || can_push);

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        id_next     = id_reg;
        type_next   = type_reg;
        mside_next  = mside_reg;
        price_next  = price_reg;
        qty_next    = qty_reg;
        ptr_next    = ptr_reg;
        side_next   = side_reg;
        eside_next  = eside_reg;
        gfd_next    = gfd_reg;
        rmctx_next  = rmctx_reg;
        best_next   = best_reg;
        bidx_next   = bidx_reg;
        pend_v_next = pend_v_reg;
        pend_next   = pend_reg;
        rcnt_next   = rcnt_reg;
        scnt_next   = scnt_reg;
        bcnt_next   = bcnt_reg;
        rd_en       = 1'b0;
        rd_addr     = {side_reg, ptr_reg[IW-1:0]};
        wr_en       = 1'b0;
        wr_addr     = {side_reg, ptr_reg[IW-1:0]};
        wr_data     = rd_data;
        emit_req    = 1'b0;
        emit_res    = '0;
        push        = '0;
        push.res    = pend_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd_next   = s_axis_tuser;
                    id_next    = s_axis_tdata[31:0];
                    type_next  = s_axis_tdata[33:32];
                    mside_next = s_axis_tdata[34];
                    price_next = s_axis_tdata[66:35];
                    qty_next   = s_axis_tdata[98:67];
                    ptr_next   = '0;
                    side_next  = SIDE_SELL;
                    rmctx_next = 1'b0;
                    rcnt_next  = '0;
                    case (s_axis_tuser)
                        CMD_BUY, CMD_SELL:
                        begin
                            if ((s_axis_tdata[33:32] == TYPE_GFD ||
                                 s_axis_tdata[33:32] == TYPE_IOC) &&
                                s_axis_tdata[66:35] != '0 && s_axis_tdata[98:67] != '0)
                            begin
                                state_next = S_FIND_RD;
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                        CMD_MODIFY, CMD_CANCEL: state_next = S_FIND_RD;
                        CMD_PRINT:              state_next = S_PR_RD;
                        default:                state_next = S_DONE;
                    endcase
                end
            end

            // Search the sell book, then the buy book, for the id
            S_FIND_RD:
            begin
                if (ptr_reg < cur_cnt)
                begin
                    rd_en      = 1'b1;
                    state_next = S_FIND_CK;
                end
                else if (side_reg == SIDE_SELL)
                begin
                    side_next = SIDE_BUY;
                    ptr_next  = '0;
                end
                else if (cmd_reg == CMD_BUY || cmd_reg == CMD_SELL)
                begin
                    eside_next = cmd_reg[0];
                    gfd_next   = (type_reg == TYPE_GFD);
                    state_next = S_MT_START;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_FIND_CK:
            begin
                if (rd_data.id == id_reg)
                begin
                    if (cmd_reg == CMD_BUY || cmd_reg == CMD_SELL)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SH_RD;
                    end
                end
                else
                begin
                    ptr_next   = ptr_inc;
                    state_next = S_FIND_RD;
                end
            end

            // Close the gap at ptr by moving the tail down one entry
            S_SH_RD:
            begin
                if ({1'b0, ptr_inc} < {1'b0, cur_cnt})
                begin
                    rd_en      = 1'b1;
                    rd_addr    = {side_reg, ptr_inc[IW-1:0]};
                    state_next = S_SH_WR;
                end
                else
                begin
                    if (side_reg == SIDE_SELL)
                    begin
                        scnt_next = scnt_reg - 1'b1;
                    end
                    else
                    begin
                        bcnt_next = bcnt_reg - 1'b1;
                    end
                    if (rmctx_reg)
                    begin
                        state_next = S_MT_START;
                    end
                    else if (cmd_reg == CMD_MODIFY)
                    begin
                        eside_next = mside_reg;
                        gfd_next   = 1'b1;
                        state_next = S_MT_START;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_SH_WR:
            begin
                wr_en      = 1'b1;
                ptr_next   = ptr_inc;
                state_next = S_SH_RD;
            end

            // Scan the opposite book for the best price
            S_MT_START:
            begin
                side_next = ~eside_reg;
                ptr_next  = '0;
                if (qty_reg != '0 && ((eside_reg ? bcnt_reg : scnt_reg) != '0))
                begin
                    state_next = S_MT_RD;
                end
                else
                begin
                    state_next = S_REST;
                end
            end

            S_MT_RD:
            begin
                if (ptr_reg < cur_cnt)
                begin
                    rd_en      = 1'b1;
                    state_next = S_MT_CK;
                end
                else
                begin
                    state_next = S_MT_DEC;
                end
            end

            S_MT_CK:
            begin
                if (ptr_reg == '0 || better)
                begin
                    best_next = rd_data;
                    bidx_next = ptr_reg[IW-1:0];
                end
                ptr_next   = ptr_inc;
                state_next = S_MT_RD;
            end

            // Trade against the best entry if the prices cross
            S_MT_DEC:
            begin
                if (!crosses)
                begin
                    state_next = S_REST;
                end
                else
                begin
                    emit_req        = 1'b1;
                    emit_res.kind   = KIND_TRADE;
                    emit_res.rid    = best_reg.id;
                    emit_res.rprice = best_reg.price;
                    emit_res.iid    = id_reg;
                    emit_res.iprice = price_reg;
                    emit_res.qty    = fill;
                    if (emit_go)
                    begin
                        qty_next = qty_reg - fill;
                        if (best_reg.qty == fill)
                        begin
                            ptr_next   = CW'(bidx_reg);
                            rmctx_next = 1'b1;
                            state_next = S_SH_RD;
                        end
                        else
                        begin
                            wr_en       = 1'b1;
                            wr_addr     = {side_reg, bidx_reg};
                            wr_data     = best_reg;
                            wr_data.qty = best_reg.qty - fill;
                            state_next  = S_MT_START;
                        end
                    end
                end
            end

            // Rest a good-for-day remainder at the tail of its book, or report that the book is full
            S_REST:
            begin
                if (qty_reg != '0 && gfd_reg)
                begin
                    if (own_cnt < CW'(BOOK_DEPTH))
                    begin
                        wr_en   = 1'b1;
                        wr_addr = {eside_reg, own_cnt[IW-1:0]};
                        wr_data = '{id: id_reg, price: price_reg, qty: qty_reg};
                        if (eside_reg == SIDE_SELL)
                        begin
                            scnt_next = scnt_reg + 1'b1;
                        end
                        else
                        begin
                            bcnt_next = bcnt_reg + 1'b1;
                        end
                        state_next = S_DONE;
                    end
                    else
                    begin
                        emit_req        = 1'b1;
                        emit_res.kind   = KIND_FULL;
                        emit_res.iid    = id_reg;
                        emit_res.iprice = price_reg;
                        emit_res.qty    = qty_reg;
                        if (emit_go)
                        begin
                            state_next = S_DONE;
                        end
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            // List the sell book, then the buy book, or report that both are empty
            S_PR_RD:
            begin
                if (ptr_reg < cur_cnt)
                begin
                    rd_en      = 1'b1;
                    state_next = S_PR_EM;
                end
                else if (side_reg == SIDE_SELL)
                begin
                    side_next = SIDE_BUY;
                    ptr_next  = '0;
                end
                else if (rcnt_reg == '0)
                begin
                    emit_req      = 1'b1;
                    emit_res.kind = KIND_EMPTY;
                    if (emit_go)
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_PR_EM:
            begin
                emit_req        = 1'b1;
                emit_res.kind   = side_reg ? KIND_SELL_ENTRY : KIND_BUY_ENTRY;
                emit_res.rid    = rd_data.id;
                emit_res.rprice = rd_data.price;
                emit_res.qty    = rd_data.qty;
                if (emit_go)
                begin
                    ptr_next   = ptr_inc;
                    state_next = S_PR_RD;
                end
            end

            // Release the held result marked as the final one
            S_DONE:
            begin
                if (!pend_v_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (can_push)
                begin
                    push.push   = 1'b1;
                    push.last   = 1'b1;
                    pend_v_next = 1'b0;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Hold the newest result; forward the previous one as not final
        if (emit_go && rcnt_reg < RES_CNT_W'(MAX_RESULTS))
        begin
            if (pend_v_reg)
            begin
                push.push = 1'b1;
                push.last = 1'b0;
            end
            pend_next   = emit_res;
            pend_v_next = 1'b1;
            rcnt_next   = rcnt_reg + 1'b1;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            pend_v_reg <= 1'b0;
            rcnt_reg   <= '0;
            scnt_reg   <= '0;
            bcnt_reg   <= '0;
            ptr_reg    <= '0;
            side_reg   <= SIDE_SELL;
            eside_reg  <= SIDE_BUY;
            gfd_reg    <= 1'b0;
            rmctx_reg  <= 1'b0;
            cmd_reg    <= CMD_PRINT;
        end
        else
        begin
            state_reg  <= state_next;
            pend_v_reg <= pend_v_next;
            rcnt_reg   <= rcnt_next;
            scnt_reg   <= scnt_next;
            bcnt_reg   <= bcnt_next;
            ptr_reg    <= ptr_next;
            side_reg   <= side_next;
            eside_reg  <= eside_next;
            gfd_reg    <= gfd_next;
            rmctx_reg  <= rmctx_next;
            cmd_reg    <= cmd_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        id_reg    <= id_next;
        type_reg  <= type_next;
        mside_reg <= mside_next;
        price_reg <= price_next;
        qty_reg   <= qty_next;
        best_reg  <= best_next;
        bidx_reg  <= bidx_next;
        pend_reg  <= pend_next;
    end

    lobm_book_ram #(
        .ADDR_W (AW)
    ) u_ram (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    lobm_out_stage u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .push_in       (push),
        .can_push      (can_push),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        scnt_reg <= CW'(BOOK_DEPTH) && bcnt_reg <= CW'(BOOK_DEPTH))
        else $error("book count above depth");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !pend_v_reg)
        else $error("result still held while idle");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> state_reg != S_IDLE)
        else $error("command accepted but sequencer idle");

    a_res_cap: assert property (@(posedge clk) disable iff (!rst_n)
        rcnt_reg <= RES_CNT_W'(MAX_RESULTS))
        else $error("result count above cap");

endmodule

@@ hdl/lobm_book_ram.sv @@
module lobm_book_ram #(
    parameter int ADDR_W = 5
) (
    input  logic                  clk,
    input  logic                  rd_en,
    input  logic [ADDR_W-1:0]     rd_addr,
    output lobm_pkg::entry_t      rd_data,
    input  logic                  wr_en,
    input  logic [ADDR_W-1:0]     wr_addr,
    input  lobm_pkg::entry_t      wr_data
);
    import lobm_pkg::*;

    entry_t mem [2**ADDR_W];
    entry_t rd_data_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/lobm_out_stage.sv @@
module lobm_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lobm_pkg::out_push_t  push_in,
    output logic                 can_push,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [159:0]         m_axis_tdata,  // rid, rprice, iid, iprice, qty
    output logic [2:0]           m_axis_tuser,  // result_kind
    output logic                 m_axis_tlast
);
    import lobm_pkg::*;

    logic    out_valid_reg;
    result_t out_res_reg;
    logic    out_last_reg;

    assign can_push = !out_valid_reg || m_axis_tready;

    // Valid flag: load on push, drop on transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (can_push)
        begin
            out_valid_reg <= push_in.push;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (can_push && push_in.push)
        begin
            out_res_reg  <= push_in.res;
            out_last_reg <= push_in.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_res_reg.kind;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {out_res_reg.qty, out_res_reg.iprice, out_res_reg.iid,
                            out_res_reg.rprice, out_res_reg.rid};

endmodule
